[design/gpsdr_pkg.sv]
// gpsdr_pkg: types, register map and constants of the gps aided dead reckoning block
// used by the register file, the core and the top level
`default_nettype none

package gpsdr_pkg;

  // number of axes and the width of an axis index
  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;

  // apb address and data widths
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic signed [15:0] ACCEL_GAIN_RST  = 16'sd3;
  localparam logic signed [15:0] VEL_GAIN_RST    = 16'sd262;
  localparam logic signed [15:0] FILTER_GAIN_RST = 16'sd655;
  localparam logic [7:0]         CORR_PERIOD_RST = 8'd14;

  // register indexes (byte address is 4 times the index)
  typedef enum logic [1:0] {
    REG_ACCEL_GAIN  = 2'd0,
    REG_VEL_GAIN    = 2'd1,
    REG_FILTER_GAIN = 2'd2,
    REG_CORR_PERIOD = 2'd3
  } reg_idx_t;

  // configuration as seen by the core
  typedef struct packed {
    logic signed [15:0] accel_gain;
    logic signed [15:0] velocity_gain;
    logic signed [15:0] filter_gain;
    logic [7:0]         correction_period;
  } cfg_t;

  // one input tick
  typedef struct packed {
    logic               enable;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               gps_valid;
    logic               correction_request;
    logic signed [15:0] gps_pos_x;
    logic signed [15:0] gps_pos_y;
    logic signed [15:0] gps_pos_z;
    logic signed [15:0] gps_vel_x;
    logic signed [15:0] gps_vel_y;
    logic signed [15:0] gps_vel_z;
  } tick_t;

  // one result
  typedef struct packed {
    logic signed [15:0] est_pos_x;
    logic signed [15:0] est_pos_y;
    logic signed [15:0] est_pos_z;
    logic signed [15:0] est_vel_x;
    logic signed [15:0] est_vel_y;
    logic signed [15:0] est_vel_z;
    logic               gps_lost;
    logic               request_taken;
  } est_t;

  // handshake between top level and core
  typedef struct packed {
    logic start;
    logic ack;
  } core_ctl_t;

  // core sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_READ  = 10'b00_0000_0010,
    ST_MUL_A = 10'b00_0000_0100,
    ST_ADD_A = 10'b00_0000_1000,
    ST_MUL_V = 10'b00_0001_0000,
    ST_ADD_V = 10'b00_0010_0000,
    ST_COR_V = 10'b00_0100_0000,
    ST_COR_P = 10'b00_1000_0000,
    ST_WRITE = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

[design/gpsdr_if.sv]
// gpsdr_tick_if and gpsdr_est_if: valid/ready channels for ticks and results
// no dependencies
`default_nettype none

interface gpsdr_tick_if;
  logic               valid;
  logic               ready;
  logic               enable;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic               gps_valid;
  logic               correction_request;
  logic signed [15:0] gps_pos_x;
  logic signed [15:0] gps_pos_y;
  logic signed [15:0] gps_pos_z;
  logic signed [15:0] gps_vel_x;
  logic signed [15:0] gps_vel_y;
  logic signed [15:0] gps_vel_z;

  modport source (
    output valid, enable, accel_x, accel_y, accel_z, gps_valid, correction_request,
           gps_pos_x, gps_pos_y, gps_pos_z, gps_vel_x, gps_vel_y, gps_vel_z,
    input  ready
  );
  modport sink (
    input  valid, enable, accel_x, accel_y, accel_z, gps_valid, correction_request,
           gps_pos_x, gps_pos_y, gps_pos_z, gps_vel_x, gps_vel_y, gps_vel_z,
    output ready
  );
endinterface

interface gpsdr_est_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] est_pos_x;
  logic signed [15:0] est_pos_y;
  logic signed [15:0] est_pos_z;
  logic signed [15:0] est_vel_x;
  logic signed [15:0] est_vel_y;
  logic signed [15:0] est_vel_z;
  logic               gps_lost;
  logic               request_taken;

  modport source (
    output valid, est_pos_x, est_pos_y, est_pos_z, est_vel_x, est_vel_y, est_vel_z,
           gps_lost, request_taken,
    input  ready
  );
  modport sink (
    input  valid, est_pos_x, est_pos_y, est_pos_z, est_vel_x, est_vel_y, est_vel_z,
           gps_lost, request_taken,
    output ready
  );
endinterface

`default_nettype wire

[design/gpsdr_regs.sv]
// gpsdr_regs: apb register file holding the gains and the correction period
// depends on gpsdr_pkg
`default_nettype none

module gpsdr_regs
  import gpsdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_gain        <= ACCEL_GAIN_RST;
      cfg.velocity_gain     <= VEL_GAIN_RST;
      cfg.filter_gain       <= FILTER_GAIN_RST;
      cfg.correction_period <= CORR_PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ACCEL_GAIN:  cfg.accel_gain        <= pwdata[15:0];
        REG_VEL_GAIN:    cfg.velocity_gain     <= pwdata[15:0];
        REG_FILTER_GAIN: cfg.filter_gain       <= pwdata[15:0];
        REG_CORR_PERIOD: cfg.correction_period <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux, gains sign extended
  always_comb begin
    case (idx)
      REG_ACCEL_GAIN:  prdata = PDATA_W'(cfg.accel_gain);
      REG_VEL_GAIN:    prdata = PDATA_W'(cfg.velocity_gain);
      REG_FILTER_GAIN: prdata = PDATA_W'(cfg.filter_gain);
      REG_CORR_PERIOD: prdata = {{(PDATA_W-8){1'b0}}, cfg.correction_period};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[design/gpsdr_core.sv]
// gpsdr_core: accumulator and error memories, shared multiplier and the per-axis sequencer
// depends on gpsdr_pkg
`default_nettype none

module gpsdr_core
  import gpsdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  tick_t     item,
  input  core_ctl_t ctl,
  output logic      done,
  output est_t      res
);

  state_t state;
  logic [AXIS_W-1:0] axis;
  logic [7:0] countdown;
  logic [NUM_AXES-1:0] acc_valid;
  logic [NUM_AXES-1:0] err_valid;
  logic corr;
  logic take;
  logic lost;

  // state memories: {velocity, position} and {velocity error, position error}
  logic [63:0] acc_mem [NUM_AXES];
  logic [31:0] err_mem [NUM_AXES];
  logic [63:0] acc_rd;
  logic [31:0] err_rd;
  logic rd_acc_valid;
  logic rd_err_valid;

  // working registers for the axis in flight
  logic [31:0] vel;
  logic [31:0] pos;
  logic signed [15:0] verr;
  logic signed [15:0] perr;
  logic signed [31:0] prod;
  logic signed [31:0] prod_sar;
  logic signed [15:0] est_pos [NUM_AXES];
  logic signed [15:0] est_vel [NUM_AXES];

  // shared multiplier
  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [31:0] mul_p;

  // per-axis selections from the tick
  logic signed [15:0] accel_sel;
  logic signed [15:0] gps_pos_sel;
  logic signed [15:0] gps_vel_sel;
  logic [15:0] verr_new;
  logic [15:0] perr_new;
  logic last_axis;

  assign done      = (state == ST_DONE);
  assign last_axis = (axis == AXIS_W'(NUM_AXES - 1));
  assign prod_sar  = prod >>> 4;
  assign mul_p     = mul_a * mul_b;
  assign verr_new  = gps_vel_sel - vel[31:16];
  assign perr_new  = gps_pos_sel - pos[31:16];

  always_comb begin
    case (axis)
      2'd0: begin
        accel_sel   = item.accel_x;
        gps_pos_sel = item.gps_pos_x;
        gps_vel_sel = item.gps_vel_x;
      end
      2'd1: begin
        accel_sel   = item.accel_y;
        gps_pos_sel = item.gps_pos_y;
        gps_vel_sel = item.gps_vel_y;
      end
      default: begin
        accel_sel   = item.accel_z;
        gps_pos_sel = item.gps_pos_z;
        gps_vel_sel = item.gps_vel_z;
      end
    endcase
  end

  // multiplier operands by step
  always_comb begin
    case (state)
      ST_MUL_A: begin
        mul_a = cfg.accel_gain;
        mul_b = accel_sel;
      end
      ST_MUL_V: begin
        mul_a = cfg.velocity_gain;
        mul_b = $signed(vel[31:16]);
      end
      ST_COR_V: begin
        mul_a = cfg.filter_gain;
        mul_b = perr;
      end
      default: begin
        mul_a = cfg.filter_gain;
        mul_b = verr;
      end
    endcase
  end

  // sequencer, countdown and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= '0;
      countdown <= CORR_PERIOD_RST;
      acc_valid <= '0;
      err_valid <= '0;
      corr      <= 1'b0;
      take      <= 1'b0;
      lost      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            axis <= '0;
            if (!item.enable) begin
              // disabled tick: accumulators read as zero from now on
              acc_valid <= '0;
              lost      <= 1'b0;
              take      <= 1'b0;
              state     <= ST_DONE;
            end else begin
              corr  <= (countdown != 8'd0);
              lost  <= (countdown == 8'd0);
              take  <= item.gps_valid & item.correction_request;
              state <= ST_READ;
              if (item.gps_valid & item.correction_request) begin
                countdown <= cfg.correction_period;
              end else if (countdown != 8'd0) begin
                countdown <= countdown - 8'd1;
              end
            end
          end
        end
        ST_READ:  state <= ST_MUL_A;
        ST_MUL_A: state <= ST_ADD_A;
        ST_ADD_A: state <= ST_MUL_V;
        ST_MUL_V: state <= ST_ADD_V;
        ST_ADD_V: state <= corr ? ST_COR_V : ST_WRITE;
        ST_COR_V: state <= ST_COR_P;
        ST_COR_P: state <= ST_WRITE;
        ST_WRITE: begin
          acc_valid[axis] <= 1'b1;
          if (take) begin
            err_valid[axis] <= 1'b1;
          end
          if (last_axis) begin
            state <= ST_DONE;
          end else begin
            axis  <= axis + AXIS_W'(1);
            state <= ST_READ;
          end
        end
        ST_DONE: begin
          if (ctl.ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // memories and datapath; one axis is read, updated and written back before the next read
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (ctl.start && !item.enable) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            est_pos[i] <= '0;
            est_vel[i] <= '0;
          end
        end
      end
      ST_READ: begin
        acc_rd       <= acc_mem[axis];
        err_rd       <= err_mem[axis];
        rd_acc_valid <= acc_valid[axis];
        rd_err_valid <= err_valid[axis];
      end
      ST_MUL_A: begin
        vel  <= rd_acc_valid ? acc_rd[63:32] : '0;
        pos  <= rd_acc_valid ? acc_rd[31:0]  : '0;
        verr <= rd_err_valid ? $signed(err_rd[31:16]) : '0;
        perr <= rd_err_valid ? $signed(err_rd[15:0])  : '0;
        prod <= mul_p;
      end
      ST_ADD_A: vel <= vel + prod;
      ST_MUL_V: prod <= mul_p;
      ST_ADD_V: begin
        pos  <= pos + prod_sar;
        prod <= mul_p;
      end
      ST_COR_V: begin
        vel  <= vel + prod;
        prod <= mul_p;
      end
      ST_COR_P: pos <= pos + prod;
      ST_WRITE: begin
        acc_mem[axis] <= {vel, pos};
        if (take) begin
          err_mem[axis] <= {verr_new, perr_new};
        end
        est_pos[axis] <= pos[31:16];
        est_vel[axis] <= vel[31:16];
      end
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    res.est_pos_x     = est_pos[0];
    res.est_pos_y     = est_pos[1];
    res.est_pos_z     = est_pos[2];
    res.est_vel_x     = est_vel[0];
    res.est_vel_y     = est_vel[1];
    res.est_vel_z     = est_vel[2];
    res.gps_lost      = lost;
    res.request_taken = take;
  end

endmodule

`default_nettype wire

[design/gps_aided_dead_reckoning.sv]
// gps_aided_dead_reckoning: top level with tick capture, result register and apb registers
// depends on gpsdr_pkg, gpsdr_if, gpsdr_regs and gpsdr_core
//
//  channel    dir  flow        payload
//  tick       in   valid/ready enable, accel_x/y/z, gps_valid, correction_request, gps_pos/vel
//  estimate   out  valid/ready est_pos_x/y/z, est_vel_x/y/z, gps_lost, request_taken
//  apb        in   psel/penable registers accel_gain, velocity_gain, filter_gain, period
//
// an enabled tick is handled one axis after another, six steps per axis, eight while a
// correction runs, through the one shared 16x16 multiplier and memory port
// a disabled tick goes straight to the done step; a new tick is taken once its result is in the output register
// a stalled output holds the core in its done step; rst is synchronous and clears the control state only
`default_nettype none

module gps_aided_dead_reckoning
  import gpsdr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  gpsdr_tick_if.sink         tick,
  gpsdr_est_if.source        estimate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t      cfg;
  tick_t     item;
  est_t      res;
  est_t      out_data;
  core_ctl_t ctl;
  logic      busy;
  logic      start;
  logic      out_valid;
  logic      core_done;
  logic      tick_xfer;

  gpsdr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpsdr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .ctl  (ctl),
    .done (core_done),
    .res  (res)
  );

  // no tick is taken while in reset
  assign tick.ready = ~busy & ~rst;
  assign tick_xfer  = tick.valid & tick.ready;
  assign ctl.start  = start;
  assign ctl.ack    = core_done & (~out_valid | estimate.ready);

  // tick capture
  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      item.enable             <= tick.enable;
      item.accel_x            <= tick.accel_x;
      item.accel_y            <= tick.accel_y;
      item.accel_z            <= tick.accel_z;
      item.gps_valid          <= tick.gps_valid;
      item.correction_request <= tick.correction_request;
      item.gps_pos_x          <= tick.gps_pos_x;
      item.gps_pos_y          <= tick.gps_pos_y;
      item.gps_pos_z          <= tick.gps_pos_z;
      item.gps_vel_x          <= tick.gps_vel_x;
      item.gps_vel_y          <= tick.gps_vel_y;
      item.gps_vel_z          <= tick.gps_vel_z;
    end
  end

  // busy from tick transfer until the result moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= tick_xfer;
      if (tick_xfer) begin
        busy <= 1'b1;
      end else if (ctl.ack) begin
        busy <= 1'b0;
      end
      if (ctl.ack) begin
        out_valid <= 1'b1;
      end else if (estimate.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.ack) begin
      out_data <= res;
    end
  end

  assign estimate.valid         = out_valid;
  assign estimate.est_pos_x     = out_data.est_pos_x;
  assign estimate.est_pos_y     = out_data.est_pos_y;
  assign estimate.est_pos_z     = out_data.est_pos_z;
  assign estimate.est_vel_x     = out_data.est_vel_x;
  assign estimate.est_vel_y     = out_data.est_vel_y;
  assign estimate.est_vel_z     = out_data.est_vel_z;
  assign estimate.gps_lost      = out_data.gps_lost;
  assign estimate.request_taken = out_data.request_taken;

  // a result only leaves the core for a tick in flight
  a_ack_busy: assert property (@(posedge clk) disable iff (rst) ctl.ack |-> busy)
    else $error("core result without a tick in flight");

  // output register fills only from a core handoff
  a_out_from_ack: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.ack))
    else $error("output valid without core handoff");

  // the core is never done in a cycle in which start is high
  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    start |-> !core_done)
    else $error("core done while starting");

endmodule

`default_nettype wire
